// ===== hdl/hng_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heightmap normal generator package
// Codes, reset values and the command and status bundles that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package hng_pkg;

    // Item actions.
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Result status codes.
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_OUTSIDE = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_GRID_COLUMNS = 2'd0;
    localparam logic [1:0] REG_GRID_ROWS    = 2'd1;
    localparam logic [1:0] REG_X_SPACING    = 2'd2;
    localparam logic [1:0] REG_Y_SPACING    = 2'd3;

    // Configuration reset values.
    localparam logic [6:0]  GRID_SIZE_RESET = 7'd64;
    localparam logic [15:0] SPACING_RESET   = 16'd256;

    // Height reads of one query.
    localparam logic [1:0] RD_X_HI = 2'd0;
    localparam logic [1:0] RD_X_LO = 2'd1;
    localparam logic [1:0] RD_Y_HI = 2'd2;
    localparam logic [1:0] RD_Y_LO = 2'd3;

    // Normal components.
    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    typedef struct packed {
        logic       load_item;
        logic       rd_issue;
        logic       rd_cap;
        logic [1:0] rd_idx;
        logic [1:0] cap_idx;
        logic       delta;
        logic       mag;
        logic       norm;
        logic       sq_mul;
        logic       sq_clr;
        logic       sq_acc;
        logic [1:0] sq_idx;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       div_store;
        logic [1:0] div_idx;
        logic       out_load;
    } hng_cmd_t;

    typedef struct packed {
        logic in_write;
        logic in_inside;
        logic norm_done;
    } hng_status_t;

endpackage

// ===== hdl/hng_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input item channel
// Valid and ready handshake carrying one write or query item.
// ----------------------------------------------------------------------------
interface hng_in_if;
    logic              valid;
    logic              ready;
    logic              action;
    logic [5:0]        column;
    logic [5:0]        row;
    logic signed [15:0] height_value;

    modport source (output valid, action, column, row, height_value, input ready);
    modport sink   (input valid, action, column, row, height_value, output ready);
endinterface

// ===== hdl/hng_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result item channel
// Valid and ready handshake carrying the status, normal and deltas of a query.
// ----------------------------------------------------------------------------
interface hng_out_if;
    logic               valid;
    logic               ready;
    logic               status;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic [14:0]        normal_z;
    logic signed [17:0] delta_x;
    logic signed [17:0] delta_y;

    modport source (output valid, status, normal_x, normal_y, normal_z, delta_x, delta_y,
                    input ready);
    modport sink   (input valid, status, normal_x, normal_y, normal_z, delta_x, delta_y,
                    output ready);
endinterface

// ===== hdl/hng_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid and ready handshake carrying a register index and write data.
// ----------------------------------------------------------------------------
interface hng_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/hng_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heightmap normal controller
// Sequences the reads, arithmetic steps and result hand-off of each query.
// ----------------------------------------------------------------------------
module hng_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 out_ready,
    output logic                 out_valid,
    input  hng_pkg::hng_status_t status,
    output hng_pkg::hng_cmd_t    cmd
);
    import hng_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_READ  = 9'b000000010,
        ST_DELTA = 9'b000000100,
        ST_MAG   = 9'b000001000,
        ST_NORM  = 9'b000010000,
        ST_SQ    = 9'b000100000,
        ST_SQRT  = 9'b001000000,
        ST_DIV   = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    localparam logic [4:0] READ_LAST = 5'd4;
    localparam logic [4:0] SQ_LAST   = 5'd3;
    localparam logic [4:0] SQRT_LAST = 5'd31;
    localparam logic [4:0] DIV_LAST  = 5'd18;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [1:0] comp_reg, comp_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        comp_next      = comp_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.load_item  = accept;
        cmd.rd_idx     = cnt_reg[1:0];
        cmd.cap_idx    = 2'(cnt_reg - 5'd1);
        cmd.sq_idx     = cnt_reg[1:0];
        cmd.div_idx    = comp_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !status.in_write)
                begin
                    cnt_next   = '0;
                    state_next = status.in_inside ? ST_READ : ST_DONE;
                end
            end
            ST_READ:
            begin
                cmd.rd_issue = (cnt_reg != READ_LAST);
                cmd.rd_cap   = (cnt_reg != '0);
                if (cnt_reg == READ_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_DELTA;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_DELTA:
            begin
                cmd.delta  = 1'b1;
                state_next = ST_MAG;
            end
            ST_MAG:
            begin
                cmd.mag    = 1'b1;
                state_next = ST_NORM;
            end
            ST_NORM:
            begin
                if (status.norm_done)
                begin
                    cnt_next   = '0;
                    state_next = ST_SQ;
                end
                else
                begin
                    cmd.norm = 1'b1;
                end
            end
            ST_SQ:
            begin
                cmd.sq_mul    = (cnt_reg != SQ_LAST);
                cmd.sq_clr    = (cnt_reg == '0);
                cmd.sq_acc    = (cnt_reg != '0);
                cmd.sqrt_init = (cnt_reg == '0);
                if (cnt_reg == SQ_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == SQRT_LAST)
                begin
                    cnt_next   = '0;
                    comp_next  = COMP_X;
                    state_next = ST_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_DIV:
            begin
                cmd.div_init  = (cnt_reg == '0);
                cmd.div_step  = (cnt_reg != '0) && (cnt_reg != DIV_LAST);
                cmd.div_store = (cnt_reg == DIV_LAST);
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next = '0;
                    if (comp_reg == COMP_Z)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        comp_next = comp_reg + 2'd1;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            comp_reg      <= COMP_X;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            comp_reg      <= comp_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/hng_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heightmap normal datapath
// Height store, configuration registers, delta and magnitude arithmetic,
// normalising shifter, square-sum, bit-serial square root and divider.
// ----------------------------------------------------------------------------
module hng_datapath #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64,
    parameter int HEIGHT_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hng_pkg::hng_cmd_t    cmd,
    output hng_pkg::hng_status_t status,
    input  logic                 in_action,
    input  logic [5:0]           in_column,
    input  logic [5:0]           in_row,
    input  logic signed [15:0]   in_height_value,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    output logic                 out_status,
    output logic signed [15:0]   out_normal_x,
    output logic signed [15:0]   out_normal_y,
    output logic [14:0]          out_normal_z,
    output logic signed [17:0]   out_delta_x,
    output logic signed [17:0]   out_delta_y
);
    import hng_pkg::*;

    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int DEPTH = MAX_ROWS * (2 ** CW);
    localparam int HB    = HEIGHT_BITS;
    localparam int DW    = (HEIGHT_BITS + 2 > 19) ? HEIGHT_BITS + 2 : 19;
    localparam logic [6:0] COL_CAP = (MAX_COLUMNS > 127) ? 7'd127 : 7'(MAX_COLUMNS);
    localparam logic [6:0] ROW_CAP = (MAX_ROWS > 127) ? 7'd127 : 7'(MAX_ROWS);
    localparam logic signed [DW-1:0] DLIM = DW'(131070);

    function automatic logic [6:0] clamp_size(input logic [6:0] v, input logic [6:0] cap);
        logic [6:0] r;
        priority if (v < 7'd2)
            r = 7'd2;
        else if (v > cap)
            r = cap;
        else
            r = v;
        return r;
    endfunction

    function automatic logic signed [17:0] sat_delta(input logic signed [DW-1:0] d);
        logic signed [17:0] r;
        priority if (d > DLIM)
            r = 18'sd131070;
        else if (d < -DLIM)
            r = -18'sd131070;
        else
            r = 18'(d);
        return r;
    endfunction

    function automatic logic [15:0] signed_field(input logic [16:0] q, input logic neg);
        logic [16:0] qs;
        logic [15:0] r;
        if (neg)
        begin
            qs = (q > 17'd32768) ? 17'd32768 : q;
            r  = 16'(-qs);
        end
        else
        begin
            r = (q > 17'd32767) ? 16'd32767 : q[15:0];
        end
        return r;
    endfunction

    // Configuration.
    logic [6:0]  cols_reg, rows_reg;
    logic [15:0] xs_reg, ys_reg;
    logic [6:0]  cols_eff, rows_eff;
    logic [15:0] xs_eff, ys_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= GRID_SIZE_RESET;
            rows_reg <= GRID_SIZE_RESET;
            xs_reg   <= SPACING_RESET;
            ys_reg   <= SPACING_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_GRID_COLUMNS: cols_reg <= cfg_data[6:0];
                REG_GRID_ROWS:    rows_reg <= cfg_data[6:0];
                REG_X_SPACING:    xs_reg   <= cfg_data;
                REG_Y_SPACING:    ys_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign cols_eff = clamp_size(cols_reg, COL_CAP);
    assign rows_eff = clamp_size(rows_reg, ROW_CAP);
    assign xs_eff   = (xs_reg == '0) ? 16'd1 : xs_reg;
    assign ys_eff   = (ys_reg == '0) ? 16'd1 : ys_reg;

    // Item latch.
    logic       in_inside;
    logic [5:0] col_reg, row_reg;
    logic       inside_reg;

    assign in_inside = ({1'b0, in_column} < cols_eff) && ({1'b0, in_row} < rows_eff);

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            col_reg    <= in_column;
            row_reg    <= in_row;
            inside_reg <= in_inside;
        end
    end

    // Height store: one write or one read per cycle, read data registered.
    logic signed [HB-1:0] mem [DEPTH];
    logic signed [HB-1:0] rd_data_reg;
    logic [RW+CW-1:0]     wr_addr, rd_addr;

    assign wr_addr = {RW'(in_row), CW'(in_column)};

    always_ff @(posedge clk)
    begin
        if (cmd.load_item && in_action == ACT_WRITE && in_inside)
            mem[wr_addr] <= HB'(in_height_value);
        if (cmd.rd_issue)
            rd_data_reg <= mem[rd_addr];
    end

    // Neighbour addresses; the border cells fall back to one-sided pairs.
    logic [6:0] c7, r7, x_hi, x_lo, y_hi, y_lo;
    logic       x_first, x_last, y_first, y_last, x_border, y_border;

    always_comb
    begin
        c7       = {1'b0, col_reg};
        r7       = {1'b0, row_reg};
        x_first  = (c7 == 7'd0);
        x_last   = (c7 == cols_eff - 7'd1);
        y_first  = (r7 == 7'd0);
        y_last   = (r7 == rows_eff - 7'd1);
        x_border = x_first || x_last;
        y_border = y_first || y_last;
        x_hi     = x_last ? c7 : c7 + 7'd1;
        x_lo     = x_first ? c7 : c7 - 7'd1;
        y_hi     = y_last ? r7 : r7 + 7'd1;
        y_lo     = y_first ? r7 : r7 - 7'd1;
        unique case (cmd.rd_idx)
            RD_X_HI: rd_addr = {RW'(r7), CW'(x_hi)};
            RD_X_LO: rd_addr = {RW'(r7), CW'(x_lo)};
            RD_Y_HI: rd_addr = {RW'(y_hi), CW'(c7)};
            RD_Y_LO: rd_addr = {RW'(y_lo), CW'(c7)};
            default: rd_addr = '0;
        endcase
    end

    logic signed [HB-1:0] hxh_reg, hxl_reg, hyh_reg, hyl_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.rd_cap)
        begin
            unique case (cmd.cap_idx)
                RD_X_HI: hxh_reg <= rd_data_reg;
                RD_X_LO: hxl_reg <= rd_data_reg;
                RD_Y_HI: hyh_reg <= rd_data_reg;
                RD_Y_LO: hyl_reg <= rd_data_reg;
                default: ;
            endcase
        end
    end

    // Deltas in Q16.1.
    logic signed [HB+1:0] x_diff, y_diff, x_dd, y_dd;
    logic signed [17:0]   dx_reg, dy_reg;

    always_comb
    begin
        x_diff = (HB + 2)'(hxh_reg) - (HB + 2)'(hxl_reg);
        y_diff = (HB + 2)'(hyh_reg) - (HB + 2)'(hyl_reg);
        x_dd   = x_border ? (x_diff <<< 1) : x_diff;
        y_dd   = y_border ? (y_diff <<< 1) : y_diff;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.delta)
        begin
            dx_reg <= sat_delta(DW'(x_dd));
            dy_reg <= sat_delta(DW'(y_dd));
        end
    end

    // Unnormalised vector magnitudes and their common normalising shift.
    logic [16:0] abs_x, abs_y;
    logic [32:0] p0, p1;
    logic [31:0] p2;
    logic [39:0] m0_reg, m1_reg, m2_reg, orv;
    logic        neg_x, neg_y, big4, hi1, lo4;

    assign abs_x = 17'(dx_reg[17] ? -dx_reg : dx_reg);
    assign abs_y = 17'(dy_reg[17] ? -dy_reg : dy_reg);
    assign p0    = 33'(abs_x) * 33'(ys_eff);
    assign p1    = 33'(abs_y) * 33'(xs_eff);
    assign p2    = 32'(xs_eff) * 32'(ys_eff);
    assign neg_x = !dx_reg[17] && (dx_reg != '0);
    assign neg_y = !dy_reg[17] && (dy_reg != '0);

    assign orv  = m0_reg | m1_reg | m2_reg;
    assign big4 = |orv[39:33];
    assign hi1  = |orv[39:30];
    assign lo4  = ~|orv[39:26];
    assign status.norm_done = !hi1 && orv[29];
    assign status.in_write  = (in_action == ACT_WRITE);
    assign status.in_inside = in_inside;

    always_ff @(posedge clk)
    begin
        if (cmd.mag)
        begin
            m0_reg <= {p0, 7'b0};
            m1_reg <= {p1, 7'b0};
            m2_reg <= {8'b0, p2};
        end
        else if (cmd.norm)
        begin
            priority if (big4)
            begin
                m0_reg <= m0_reg >> 4;
                m1_reg <= m1_reg >> 4;
                m2_reg <= m2_reg >> 4;
            end
            else if (hi1)
            begin
                m0_reg <= m0_reg >> 1;
                m1_reg <= m1_reg >> 1;
                m2_reg <= m2_reg >> 1;
            end
            else if (lo4)
            begin
                m0_reg <= m0_reg << 4;
                m1_reg <= m1_reg << 4;
                m2_reg <= m2_reg << 4;
            end
            else
            begin
                m0_reg <= m0_reg << 1;
                m1_reg <= m1_reg << 1;
                m2_reg <= m2_reg << 1;
            end
        end
    end

    // Sum of squares, one product per cycle.
    logic [29:0] sq_op;
    logic [59:0] sq_prod, prod_reg;
    logic [61:0] acc_reg;

    always_comb
    begin
        unique case (cmd.sq_idx)
            COMP_X:  sq_op = m0_reg[29:0];
            COMP_Y:  sq_op = m1_reg[29:0];
            COMP_Z:  sq_op = m2_reg[29:0];
            default: sq_op = '0;
        endcase
    end

    assign sq_prod = sq_op * sq_op;

    // Square root, one result bit per cycle; the sum register is worked down in place.
    logic [62:0] res_reg, bit_reg, sq_trial;
    logic        sq_ge;

    assign sq_trial = res_reg + bit_reg;
    assign sq_ge    = ({1'b0, acc_reg} >= sq_trial);

    always_ff @(posedge clk)
    begin
        if (cmd.sq_mul)
            prod_reg <= sq_prod;
        if (cmd.sq_clr)
            acc_reg <= '0;
        else if (cmd.sq_acc)
            acc_reg <= acc_reg + 62'(prod_reg);
        else if (cmd.sqrt_step && sq_ge)
            acc_reg <= acc_reg - 62'(sq_trial);
        if (cmd.sqrt_init)
        begin
            res_reg <= '0;
            bit_reg <= 63'(1) << 62;
        end
        else if (cmd.sqrt_step)
        begin
            res_reg <= sq_ge ? (res_reg >> 1) + bit_reg : res_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
    end

    // Rounded division of each magnitude by the root, one quotient bit per cycle.
    logic [30:0] root;
    logic [29:0] div_op;
    logic [45:0] num;
    logic [30:0] rem_reg;
    logic [16:0] qlo_reg, q_reg;
    logic [31:0] div_trial;
    logic        div_ge;

    assign root = (res_reg[30:0] == '0) ? 31'd1 : res_reg[30:0];

    always_comb
    begin
        unique case (cmd.div_idx)
            COMP_X:  div_op = m0_reg[29:0];
            COMP_Y:  div_op = m1_reg[29:0];
            COMP_Z:  div_op = m2_reg[29:0];
            default: div_op = '0;
        endcase
    end

    assign num       = {1'b0, div_op, 15'b0} + 46'(root[30:1]);
    assign div_trial = {rem_reg, qlo_reg[16]};
    assign div_ge    = (div_trial >= {1'b0, root});

    logic signed [15:0] nx_reg, ny_reg;
    logic [14:0]        nz_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            rem_reg <= 31'(num[45:17]);
            qlo_reg <= num[16:0];
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= div_ge ? 31'(div_trial - {1'b0, root}) : div_trial[30:0];
            qlo_reg <= qlo_reg << 1;
            q_reg   <= {q_reg[15:0], div_ge};
        end
        if (cmd.div_store)
        begin
            unique case (cmd.div_idx)
                COMP_X:  nx_reg <= signed_field(q_reg, neg_x);
                COMP_Y:  ny_reg <= signed_field(q_reg, neg_y);
                COMP_Z:  nz_reg <= (q_reg > 17'd32767) ? 15'd32767 : q_reg[14:0];
                default: ;
            endcase
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status   <= inside_reg ? STATUS_OK : STATUS_OUTSIDE;
            out_normal_x <= inside_reg ? nx_reg : '0;
            out_normal_y <= inside_reg ? ny_reg : '0;
            out_normal_z <= inside_reg ? nz_reg : '0;
            out_delta_x  <= inside_reg ? dx_reg : '0;
            out_delta_y  <= inside_reg ? dy_reg : '0;
        end
    end

endmodule

// ===== hdl/heightmap_normal_generator.sv =====
`timescale 1ns / 1ps
// A write leaves the block idle, so the next item can be taken in the cycle after.
// A query inside the grid passes through the reads, the deltas, the magnitudes,
// the normalising shift, the square-sum, the bit-serial square root and three
// serial divisions. A query outside the grid goes straight to its error result.
// One query at a time; no item is taken while a query is at work.
// Reset clears control and configuration; the height store has no clearing pass.
// ----------------------------------------------------------------------------
// Heightmap normal generator
// Stores a grid of signed heights and answers queries with central-difference
// deltas, one-sided at the grid border, and the unit surface normal in Q1.15.
// ----------------------------------------------------------------------------
module heightmap_normal_generator #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64,
    parameter int HEIGHT_BITS = 16
) (
    input logic      clk,
    input logic      rst_n,
    hng_in_if.sink   in_ch,
    hng_out_if.source out_ch,
    hng_cfg_if.sink  cfg_ch
);
    import hng_pkg::*;

    hng_cmd_t    cmd;
    hng_status_t status;

    // Configuration writes must arrive only while idle; unchecked by the block.
    assign cfg_ch.ready = 1'b1;

    // The controller owns the handshakes and walks each query inside the grid
    // through the reads, the delta and magnitude stages, the normalising shift,
    // the square-sum, the square root and the three divisions.
    hng_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the height store, the configuration and every
    // arithmetic register, and presents the result register on the output.
    hng_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .in_action       (in_ch.action),
        .in_column       (in_ch.column),
        .in_row          (in_ch.row),
        .in_height_value (in_ch.height_value),
        .cfg_write       (cfg_ch.valid && cfg_ch.ready),
        .cfg_index       (cfg_ch.index),
        .cfg_data        (cfg_ch.data),
        .out_status      (out_ch.status),
        .out_normal_x    (out_ch.normal_x),
        .out_normal_y    (out_ch.normal_y),
        .out_normal_z    (out_ch.normal_z),
        .out_delta_x     (out_ch.delta_x),
        .out_delta_y     (out_ch.delta_y)
    );

    // An accepted query holds off the next item.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready && in_ch.action == ACT_QUERY |=> !in_ch.ready)
        else $error("input taken while a query is at work");

    // A new result is only loaded from the final state, never while idle.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> !$past(in_ch.ready))
        else $error("result appeared without a query at work");

    // An error result carries zero deltas and a zero normal; normal_z is checked.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.status == STATUS_OUTSIDE |->
            out_ch.normal_z == '0 && out_ch.delta_x == '0 && out_ch.delta_y == '0)
        else $error("error result with nonzero fields");

endmodule

// ===== dv/hng_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heightmap normal generator checker
// Watches the configuration, item and result channels, keeps its own height
// grid and settings, works out the normal and deltas of every query and
// compares each result item with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module hng_checker
    import hng_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    hng_in_if    in_ch,
    hng_out_if   out_ch,
    hng_cfg_if   cfg_ch,
    output int   fail_count,
    output int   pending,
    output int   queries_checked,
    output int   outside_checked
);

    typedef struct packed {
        logic               status;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic [14:0]        normal_z;
        logic signed [17:0] delta_x;
        logic signed [17:0] delta_y;
    } surface_result_t;

    localparam longint DELTA_SAT = 131070;

    surface_result_t    surface_queue[$];
    logic signed [15:0] heights[64*64];
    logic [6:0]         cols_reg;
    logic [6:0]         rows_reg;
    logic [15:0]        xs_reg;
    logic [15:0]        ys_reg;

    function automatic int clamp_size(logic [6:0] v);
        return (v < 2) ? 2 : ((v > 64) ? 64 : int'(v));
    endfunction

    function automatic longint height_at(int c, int r);
        return longint'(heights[r*64 + c]);
    endfunction

    function automatic longint clip_delta(longint d);
        return (d > DELTA_SAT) ? DELTA_SAT : ((d < -DELTA_SAT) ? -DELTA_SAT : d);
    endfunction

    function automatic longint unsigned floor_root(longint unsigned s);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b   = 64'h4000_0000_0000_0000;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= res + b) begin
                s   = s - (res + b);
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // Rounded Q1.15 component; negative values may reach full scale.
    function automatic logic [15:0] unit_component(longint unsigned m, bit neg,
                                                   longint unsigned root);
        longint unsigned q;
        q = (m * 32768 + root / 2) / root;
        if (neg) begin
            if (q > 32768) q = 32768;
            return 16'(-q);
        end
        if (q > 32767) q = 32767;
        return 16'(q);
    endfunction

    function automatic surface_result_t surface_of(int c, int r);
        surface_result_t res;
        int              cols;
        int              rows;
        longint          dx;
        longint          dy;
        longint unsigned xs;
        longint unsigned ys;
        longint unsigned m0;
        longint unsigned m1;
        longint unsigned m2;
        longint unsigned mx;
        longint unsigned root;
        cols = clamp_size(cols_reg);
        rows = clamp_size(rows_reg);
        res  = '0;
        if (c >= cols || r >= rows) begin
            res.status = STATUS_OUTSIDE;
            return res;
        end
        if (c == 0)             dx = 2 * (height_at(1, r) - height_at(0, r));
        else if (c == cols - 1) dx = 2 * (height_at(c, r) - height_at(c - 1, r));
        else                    dx = height_at(c + 1, r) - height_at(c - 1, r);
        if (r == 0)             dy = 2 * (height_at(c, 1) - height_at(c, 0));
        else if (r == rows - 1) dy = 2 * (height_at(c, r) - height_at(c, r - 1));
        else                    dy = height_at(c, r + 1) - height_at(c, r - 1);
        dx = clip_delta(dx);
        dy = clip_delta(dy);
        xs = (xs_reg == 0) ? 1 : longint'(xs_reg);
        ys = (ys_reg == 0) ? 1 : longint'(ys_reg);
        m0 = longint'(dx < 0 ? -dx : dx) * 128 * ys;
        m1 = longint'(dy < 0 ? -dy : dy) * 128 * xs;
        m2 = xs * ys;
        mx = m0;
        if (m1 > mx) mx = m1;
        if (m2 > mx) mx = m2;
        // Bring the largest magnitude into [2^29, 2^30) by a common shift.
        while (mx >= (64'd1 << 30)) begin
            m0 >>= 1; m1 >>= 1; m2 >>= 1; mx >>= 1;
        end
        while (mx < (64'd1 << 29)) begin
            m0 <<= 1; m1 <<= 1; m2 <<= 1; mx <<= 1;
        end
        root = floor_root(m0 * m0 + m1 * m1 + m2 * m2);
        if (root == 0) root = 1;
        res.status   = STATUS_OK;
        res.normal_x = unit_component(m0, dx > 0, root);
        res.normal_y = unit_component(m1, dy > 0, root);
        res.normal_z = 15'(unit_component(m2, 1'b0, root));
        res.delta_x  = 18'(dx);
        res.delta_y  = 18'(dy);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        surface_result_t want;
        if (!rst_n) begin
            cols_reg        = GRID_SIZE_RESET;
            rows_reg        = GRID_SIZE_RESET;
            xs_reg          = SPACING_RESET;
            ys_reg          = SPACING_RESET;
            fail_count      = 0;
            pending         = 0;
            queries_checked = 0;
            outside_checked = 0;
            surface_queue.delete();
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (surface_queue.size() == 0) begin
                    $error("result item with no query outstanding");
                    fail_count++;
                end else begin
                    want = surface_queue.pop_front();
                    if (out_ch.status !== want.status) begin
                        $error("status expected %0d got %0d", want.status, out_ch.status);
                        fail_count++;
                    end
                    if (out_ch.normal_x !== want.normal_x) begin
                        $error("normal_x expected %0d got %0d", want.normal_x, out_ch.normal_x);
                        fail_count++;
                    end
                    if (out_ch.normal_y !== want.normal_y) begin
                        $error("normal_y expected %0d got %0d", want.normal_y, out_ch.normal_y);
                        fail_count++;
                    end
                    if (out_ch.normal_z !== want.normal_z) begin
                        $error("normal_z expected %0d got %0d", want.normal_z, out_ch.normal_z);
                        fail_count++;
                    end
                    if (out_ch.delta_x !== want.delta_x) begin
                        $error("delta_x expected %0d got %0d", want.delta_x, out_ch.delta_x);
                        fail_count++;
                    end
                    if (out_ch.delta_y !== want.delta_y) begin
                        $error("delta_y expected %0d got %0d", want.delta_y, out_ch.delta_y);
                        fail_count++;
                    end
                    if (want.status == STATUS_OUTSIDE) outside_checked++;
                    else                               queries_checked++;
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    REG_GRID_COLUMNS: cols_reg = cfg_ch.data[6:0];
                    REG_GRID_ROWS:    rows_reg = cfg_ch.data[6:0];
                    REG_X_SPACING:    xs_reg   = cfg_ch.data;
                    REG_Y_SPACING:    ys_reg   = cfg_ch.data;
                    default:          ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                if (in_ch.action == ACT_QUERY) begin
                    surface_queue.push_back(surface_of(int'(in_ch.column), int'(in_ch.row)));
                end else if (int'(in_ch.column) < clamp_size(cols_reg) &&
                             int'(in_ch.row) < clamp_size(rows_reg)) begin
                    heights[int'(in_ch.row)*64 + int'(in_ch.column)] = in_ch.height_value;
                end
            end
            pending = surface_queue.size();
        end
    end

endmodule

// ===== dv/tb_heightmap_normal_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heightmap normal generator testbench
// Drives height writes and normal queries through several grid sizes and
// spacings, with random idling on both channels, while a checker module
// predicts every result item and counts mismatches for the verdict here.
// ----------------------------------------------------------------------------
module tb_heightmap_normal_generator;
    import hng_pkg::*;

    // Cycles without any handshake before the run is declared hung, well above
    // the long result hold-off and the time that one query needs.
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int ITEM_TARGET = 750;

    logic clk;
    logic rst_n;

    hng_in_if  in_ch();
    hng_out_if out_ch();
    hng_cfg_if cfg_ch();

    int fail_count;
    int pending;
    int queries_checked;
    int outside_checked;

    // Stimulus-side view of the grid: which cells have been written, so that
    // no query ever reads a cell that holds no defined height.
    bit          written[64*64];
    logic [6:0]  cols_now;
    logic [6:0]  rows_now;
    int          items_sent;
    int          phases;
    bit          calm;
    bit          hold_req;

    heightmap_normal_generator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    hng_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_ch           (in_ch),
        .out_ch          (out_ch),
        .cfg_ch          (cfg_ch),
        .fail_count      (fail_count),
        .pending         (pending),
        .queries_checked (queries_checked),
        .outside_checked (outside_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int grid_size(logic [6:0] v);
        return (v < 2) ? 2 : ((v > 64) ? 64 : int'(v));
    endfunction

    // Heights lean towards the extremes so that the deltas often reach their largest magnitudes.
    function automatic logic signed [15:0] pick_height();
        case ($urandom_range(0, 5))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'($urandom_range(0, 64)) - 16'sd32;
            default: return 16'($urandom);
        endcase
    endfunction

    // Offers one item and holds it until the block takes it. Outside the last
    // part of the run a random gap may come first.
    task automatic send_item(logic act, int c, int r, logic signed [15:0] h);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.action       <= act;
        in_ch.column       <= 6'(c);
        in_ch.row          <= 6'(r);
        in_ch.height_value <= h;
        do @(posedge clk); while (!in_ch.ready);
        items_sent++;
        if (act == ACT_WRITE && c < grid_size(cols_now) && r < grid_size(rows_now))
            written[r*64 + c] = 1'b1;
    endtask

    // Queries a cell, first writing any of the cells that it reads which
    // still hold no height. Cells outside the grid are queried as they are.
    task automatic ask_cell(int c, int r);
        int cols;
        int rows;
        int nb[4];
        cols = grid_size(cols_now);
        rows = grid_size(rows_now);
        if (c < cols && r < rows) begin
            nb[0] = r*64 + ((c == 0) ? 1 : ((c == cols - 1) ? c : c + 1));
            nb[1] = r*64 + ((c == 0) ? 0 : c - 1);
            nb[2] = ((r == 0) ? 1 : ((r == rows - 1) ? r : r + 1))*64 + c;
            nb[3] = ((r == 0) ? 0 : r - 1)*64 + c;
            foreach (nb[i])
                if (!written[nb[i]])
                    send_item(ACT_WRITE, nb[i] % 64, nb[i] / 64, pick_height());
        end
        send_item(ACT_QUERY, c, r, 16'($urandom));
    endtask

    // Waits until every query has been answered.
    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // All four registers are rewritten, and only while the block is idle.
    task automatic set_grid(logic [6:0] c, logic [6:0] r, logic [15:0] xs, logic [15:0] ys);
        drain();
        write_reg(REG_GRID_COLUMNS, {9'd0, c});
        write_reg(REG_GRID_ROWS, {9'd0, r});
        write_reg(REG_X_SPACING, xs);
        write_reg(REG_Y_SPACING, ys);
        cols_now = c;
        rows_now = r;
        phases++;
    endtask

    function automatic logic [6:0] pick_size();
        case ($urandom_range(0, 7))
            0:       return 7'd0;
            1:       return 7'd127;
            2:       return 7'd64;
            3:       return 7'($urandom_range(2, 64));
            default: return 7'($urandom_range(2, 9));
        endcase
    endfunction

    function automatic logic [15:0] pick_spacing();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'hFFFF;
            3:       return 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    // The receiver idles in bursts, or holds off for a long stretch on request.
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge clk iff rst_n);
        forever begin
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    // Watchdog: any accepted item on any channel restarts the count.
    initial
    begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready) || !rst_n)
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("timeout after %0d quiet cycles", quiet);
                $display("heightmap_normal_generator: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        int c;
        int r;
        int cols;
        int rows;
        int phase_len;
        int k;
        in_ch.valid        = 1'b0;
        in_ch.action       = ACT_WRITE;
        in_ch.column       = '0;
        in_ch.row          = '0;
        in_ch.height_value = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = REG_GRID_COLUMNS;
        cfg_ch.data        = '0;
        cols_now           = GRID_SIZE_RESET;
        rows_now           = GRID_SIZE_RESET;
        items_sent         = 0;
        phases             = 0;
        calm               = 1'b0;
        hold_req           = 1'b0;
        rst_n              = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a 3x3 grid with alternating extreme heights, the finest
        // and the coarsest spacing, then three corners, the centre and cells outside the grid.
        set_grid(7'd3, 7'd3, 16'd1, 16'hFFFF);
        for (r = 0; r < 3; r++)
            for (c = 0; c < 3; c++)
                send_item(ACT_WRITE, c, r, ((c + r) % 2 == 0) ? 16'sh7FFF : 16'sh8000);
        send_item(ACT_WRITE, 5, 5, 16'sh1234);     // outside the grid: ignored
        ask_cell(0, 0);
        ask_cell(1, 1);
        ask_cell(2, 2);
        ask_cell(2, 0);
        ask_cell(3, 0);                             // column just past the edge
        ask_cell(0, 3);                             // row just past the edge
        ask_cell(63, 63);
        // Oversized and undersized settings clamp; zero spacing counts as one.
        set_grid(7'd127, 7'd0, 16'd0, 16'd0);
        ask_cell(1, 1);
        ask_cell(1, 0);
        ask_cell(2, 1);                             // inside a two-row grid, on its last row
        set_grid(7'd64, 7'd64, 16'hFFFF, 16'd1);
        ask_cell(0, 0);
        ask_cell(63, 63);

        // Random phases, each under a fresh setting of every register.
        while (items_sent < ITEM_TARGET) begin
            set_grid(pick_size(), pick_size(), pick_spacing(), pick_spacing());
            cols      = grid_size(cols_now);
            rows      = grid_size(rows_now);
            phase_len = $urandom_range(40, 100);
            for (k = 0; k < phase_len && items_sent < ITEM_TARGET; k++) begin
                calm = (items_sent >= ITEM_TARGET - 100);
                // Part way into the second phase the receiver holds off while
                // queries keep coming; in the third the sender waits for every answer.
                if (k == 10 && phases == 5) hold_req = 1'b1;
                if (k == 20 && phases == 6) drain();
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8:
                        ask_cell($urandom_range(0, cols - 1), $urandom_range(0, rows - 1));
                    9, 10:
                        ask_cell($urandom_range(0, 63), $urandom_range(0, 63));
                    11:
                        send_item(ACT_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                                  pick_height());
                    default:
                        send_item(ACT_WRITE, $urandom_range(0, cols - 1),
                                  $urandom_range(0, rows - 1), pick_height());
                endcase
            end
        end

        drain();
        repeat (150) @(posedge clk);
        $display("%0d items over %0d grid settings; %0d in-grid and %0d outside queries compared",
                 items_sent, phases, queries_checked, outside_checked);
        if (fail_count == 0) begin
            $display("heightmap_normal_generator: match");
        end else begin
            $display("%0d field mismatches", fail_count);
            $display("heightmap_normal_generator: mismatch");
        end
        $finish;
    end

endmodule

// ===== heightmap_normal_generator.f =====
hdl/hng_pkg.sv
hdl/hng_in_if.sv
hdl/hng_out_if.sv
hdl/hng_cfg_if.sv
hdl/hng_ctrl.sv
hdl/hng_datapath.sv
hdl/heightmap_normal_generator.sv
dv/hng_checker.sv
dv/tb_heightmap_normal_generator.sv
